// File: hdl/obt_pkg.sv
`timescale 1ns / 1ps

package obt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam int ID_W    = 64;
    localparam int PRICE_W = 32;
    localparam int VOL_W   = 32;
    localparam int KEY_W   = PRICE_W + ID_W;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_EXEC = 2'd1,
        CMD_DEL  = 2'd2,
        CMD_DUMP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE,
        S_OUT
    } t_state;

    // one table slot as held in the entry memory
    typedef struct packed {
        logic               side;
        logic [ID_W-1:0]    order_id;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
    } t_entry;

    // flags from the shared compare unit
    typedef struct packed {
        logic             id_eq;
        logic             side_eq;
        logic             above_bound;
        logic             below_best;
        logic             vol_le;
        logic [VOL_W-1:0] vol_rem;
    } t_cmp_res;

endpackage

// File: hdl/obt_mem.sv
`timescale 1ns / 1ps

module obt_mem #(
    parameter int DEPTH = obt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  obt_pkg::t_entry            i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output obt_pkg::t_entry            o_rdata
);
    import obt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/obt_cmp.sv
`timescale 1ns / 1ps

module obt_cmp (
    input  obt_pkg::t_entry                i_entry,
    input  logic                           i_side,
    input  logic [obt_pkg::ID_W-1:0]       i_order_id,
    input  logic [obt_pkg::VOL_W-1:0]      i_volume,
    input  logic [obt_pkg::KEY_W-1:0]      i_bound,
    input  logic [obt_pkg::KEY_W-1:0]      i_best,
    output obt_pkg::t_cmp_res              o_res
);
    import obt_pkg::*;

    logic [KEY_W-1:0] w_key;

    // sort key: price first, order id breaks ties
    assign w_key = {i_entry.price, i_entry.order_id};

    always_comb begin
        o_res.id_eq       = (i_entry.order_id == i_order_id);
        o_res.side_eq     = (i_entry.side == i_side);
        o_res.above_bound = (w_key > i_bound);
        o_res.below_best  = (w_key < i_best);
        o_res.vol_le      = (i_entry.volume <= i_volume);
        o_res.vol_rem     = i_entry.volume - i_volume;
    end

endmodule

// File: hdl/order_book_table.sv
// Add, execute and delete: one pass over every slot, then one result word; the block
// takes no new command until that word is taken.
// Dump of a side holding n entries: n passes over every slot
// (one pass when the side is empty), one result word per pass.
// Each pass reads the slots in turn through the single read port of the entry memory and the one compare unit.
// Reset (synchronous, active low) empties the table at once; no clearing pass.
`timescale 1ns / 1ps

module order_book_table #(
    parameter int TABLE_DEPTH = obt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_cmd,
    input  logic                          i_side,
    input  logic [obt_pkg::ID_W-1:0]      i_order_id,
    input  logic [obt_pkg::PRICE_W-1:0]   i_price,
    input  logic [obt_pkg::VOL_W-1:0]     i_volume,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic                          o_entry_valid,
    output logic [obt_pkg::ID_W-1:0]      o_out_order_id,
    output logic [obt_pkg::PRICE_W-1:0]   o_out_price,
    output logic [obt_pkg::VOL_W-1:0]     o_out_volume,
    output logic                          o_last
);
    import obt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);      // slot index
    localparam int CW = $clog2(TABLE_DEPTH + 1);  // counts up to the depth

    // sequencer
    t_state r_state, n_state;

    // captured command word
    t_cmd                r_cmd,   n_cmd;
    logic                r_side,  n_side;
    logic [ID_W-1:0]     r_id,    n_id;
    logic [PRICE_W-1:0]  r_price, n_price;
    logic [VOL_W-1:0]    r_vol,   n_vol;

    // scan pointer and read pipe
    logic [CW-1:0]       r_idx,    n_idx;
    logic                r_rd_vld, n_rd_vld;
    logic [IW-1:0]       r_rd_idx, n_rd_idx;

    // slot occupancy, one flop per slot
    logic [TABLE_DEPTH-1:0] r_used, n_used;

    // add lookup
    logic                r_hit_found,  n_hit_found;
    logic [IW-1:0]       r_hit_idx,    n_hit_idx;
    logic                r_free_found, n_free_found;
    logic [IW-1:0]       r_free_idx,   n_free_idx;

    // execute / delete
    logic                r_found, n_found;

    // dump: selection sort, one minimum per pass above the last key emitted
    logic [CW-1:0]       r_count,   n_count;
    logic [CW-1:0]       r_emitted, n_emitted;
    logic                r_have_bound, n_have_bound;
    logic [KEY_W-1:0]    r_bound,   n_bound;
    logic                r_best_found, n_best_found;
    t_entry              r_best,    n_best;

    // result register
    logic                r_o_valid,  n_o_valid;
    t_status             r_o_status, n_o_status;
    logic                r_o_entry_valid, n_o_entry_valid;
    logic [ID_W-1:0]     r_o_id,     n_o_id;
    logic [PRICE_W-1:0]  r_o_price,  n_o_price;
    logic [VOL_W-1:0]    r_o_vol,    n_o_vol;
    logic                r_o_last,   n_o_last;

    // memory and compare unit hookup
    logic                w_we;
    logic [IW-1:0]       w_waddr;
    t_entry              w_wdata;
    logic [IW-1:0]       w_raddr;
    t_entry              w_rdata;
    t_cmp_res            w_cmp;
    logic                w_slot_used;
    logic [CW-1:0]       w_emit_next;

    obt_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    obt_cmp u_cmp (
        .i_entry    (w_rdata),
        .i_side     (r_side),
        .i_order_id (r_id),
        .i_volume   (r_vol),
        .i_bound    (r_bound),
        .i_best     ({r_best.price, r_best.order_id}),
        .o_res      (w_cmp)
    );

    // read address: beyond the last slot the pointer parks on slot zero
    assign w_raddr     = (r_idx < CW'(TABLE_DEPTH)) ? r_idx[IW-1:0] : '0;
    assign w_slot_used = r_used[r_rd_idx];
    assign w_emit_next = r_emitted + CW'(1);

    always_comb begin
        n_state         = r_state;
        n_cmd           = r_cmd;
        n_side          = r_side;
        n_id            = r_id;
        n_price         = r_price;
        n_vol           = r_vol;
        n_idx           = r_idx;
        n_rd_vld        = 1'b0;
        n_rd_idx        = r_rd_idx;
        n_used          = r_used;
        n_hit_found     = r_hit_found;
        n_hit_idx       = r_hit_idx;
        n_free_found    = r_free_found;
        n_free_idx      = r_free_idx;
        n_found         = r_found;
        n_count         = r_count;
        n_emitted       = r_emitted;
        n_have_bound    = r_have_bound;
        n_bound         = r_bound;
        n_best_found    = r_best_found;
        n_best          = r_best;
        n_o_valid       = r_o_valid;
        n_o_status      = r_o_status;
        n_o_entry_valid = r_o_entry_valid;
        n_o_id          = r_o_id;
        n_o_price       = r_o_price;
        n_o_vol         = r_o_vol;
        n_o_last        = r_o_last;
        w_we            = 1'b0;
        w_waddr         = r_rd_idx;
        w_wdata         = '{side: r_side, order_id: r_id, price: r_price, volume: r_vol};

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd        = t_cmd'(i_cmd);
                    n_side       = i_side;
                    n_id         = i_order_id;
                    n_price      = i_price;
                    n_vol        = i_volume;
                    n_idx        = '0;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                    n_found      = 1'b0;
                    n_count      = '0;
                    n_emitted    = '0;
                    n_have_bound = 1'b0;
                    n_best_found = 1'b0;
                    n_state      = S_SCAN;
                end
            end

            S_SCAN: begin
                // issue side: one slot read a cycle
                if (r_idx < CW'(TABLE_DEPTH)) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[IW-1:0];
                    n_idx    = r_idx + CW'(1);
                end
                // evaluate side: data of the slot read last cycle
                if (r_rd_vld) begin
                    case (r_cmd)
                        CMD_ADD: begin
                            if (w_slot_used && w_cmp.side_eq && w_cmp.id_eq
                                && !r_hit_found) begin
                                n_hit_found = 1'b1;
                                n_hit_idx   = r_rd_idx;
                            end
                            if (!w_slot_used && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_rd_idx;
                            end
                        end
                        CMD_EXEC, CMD_DEL: begin
                            if (w_slot_used && w_cmp.id_eq) begin
                                n_found = 1'b1;
                                if (r_cmd == CMD_DEL || w_cmp.vol_le) begin
                                    n_used[r_rd_idx] = 1'b0;
                                end else begin
                                    w_we           = 1'b1;
                                    w_waddr        = r_rd_idx;
                                    w_wdata        = w_rdata;
                                    w_wdata.volume = w_cmp.vol_rem;
                                end
                            end
                        end
                        CMD_DUMP: begin
                            if (w_slot_used && w_cmp.side_eq) begin
                                n_count = r_count + CW'(1);
                                if ((!r_have_bound || w_cmp.above_bound)
                                    && (!r_best_found || w_cmp.below_best)) begin
                                    n_best_found = 1'b1;
                                    n_best       = w_rdata;
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (r_rd_idx == IW'(TABLE_DEPTH - 1)) begin
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                n_o_valid       = 1'b1;
                n_o_status      = ST_DONE;
                n_o_entry_valid = 1'b0;
                n_o_id          = '0;
                n_o_price       = '0;
                n_o_vol         = '0;
                n_o_last        = 1'b1;
                n_state         = S_OUT;
                case (r_cmd)
                    CMD_ADD: begin
                        if (r_hit_found) begin
                            w_we    = 1'b1;
                            w_waddr = r_hit_idx;
                        end else if (r_free_found) begin
                            w_we               = 1'b1;
                            w_waddr            = r_free_idx;
                            n_used[r_free_idx] = 1'b1;
                        end else begin
                            n_o_status = ST_FULL;
                        end
                    end
                    CMD_EXEC, CMD_DEL: begin
                        n_o_status = r_found ? ST_DONE : ST_NOT_FOUND;
                    end
                    CMD_DUMP: begin
                        if (r_best_found) begin
                            n_o_entry_valid = 1'b1;
                            n_o_id          = r_best.order_id;
                            n_o_price       = r_best.price;
                            n_o_vol         = r_best.volume;
                            n_o_last        = (w_emit_next == r_count);
                            n_emitted       = w_emit_next;
                            n_bound         = {r_best.price, r_best.order_id};
                            n_have_bound    = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            S_OUT: begin
                if (!i_stall) begin
                    n_o_valid = 1'b0;
                    if (r_cmd == CMD_DUMP && !r_o_last) begin
                        // next pass for the next-larger key
                        n_idx        = '0;
                        n_count      = '0;
                        n_best_found = 1'b0;
                        n_state      = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_used       <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_found      <= 1'b0;
            r_count      <= '0;
            r_emitted    <= '0;
            r_have_bound <= 1'b0;
            r_best_found <= 1'b0;
            r_o_valid    <= 1'b0;
            r_o_last     <= 1'b1;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_rd_vld     <= n_rd_vld;
            r_used       <= n_used;
            r_hit_found  <= n_hit_found;
            r_free_found <= n_free_found;
            r_found      <= n_found;
            r_count      <= n_count;
            r_emitted    <= n_emitted;
            r_have_bound <= n_have_bound;
            r_best_found <= n_best_found;
            r_o_valid    <= n_o_valid;
            r_o_last     <= n_o_last;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_cmd           <= n_cmd;
        r_side          <= n_side;
        r_id            <= n_id;
        r_price         <= n_price;
        r_vol           <= n_vol;
        r_rd_idx        <= n_rd_idx;
        r_hit_idx       <= n_hit_idx;
        r_free_idx      <= n_free_idx;
        r_bound         <= n_bound;
        r_best          <= n_best;
        r_o_status      <= n_o_status;
        r_o_entry_valid <= n_o_entry_valid;
        r_o_id          <= n_o_id;
        r_o_price       <= n_o_price;
        r_o_vol         <= n_o_vol;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_entry_valid  = r_o_entry_valid;
    assign o_out_order_id = r_o_id;
    assign o_out_price    = r_o_price;
    assign o_out_volume   = r_o_vol;
    assign o_last         = r_o_last;

    // a dump never emits more words than its side holds
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_cmd == CMD_DUMP) |-> (r_emitted <= r_count))
        else $error("dump emitted more words than entries");

    // single-word commands close at once and carry no entry
    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cmd != CMD_DUMP) |-> (o_last && !o_entry_valid))
        else $error("add/execute/delete result malformed");

    // read pipe stays inside the table
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_rd_idx < IW'(TABLE_DEPTH - 1) || r_rd_idx == IW'(TABLE_DEPTH - 1)))
        else $error("slot read beyond table depth");

    // no scan read left in flight once the block is ready
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_rd_vld && !r_o_valid))
        else $error("activity while idle");

    // an add that finds no existing key but a free slot leaves that slot occupied
    a_add_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_cmd == CMD_ADD && !r_hit_found && r_free_found)
        |=> r_used[r_free_idx])
        else $error("add did not claim free slot");

endmodule

// File: tb/obt_tb_pkg.sv
`timescale 1ns / 1ps

package obt_tb_pkg;

    import obt_pkg::*;

    // one result word as seen on the output channel
    typedef struct packed {
        t_status            status;
        logic               entry_valid;
        logic [ID_W-1:0]    order_id;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
        logic               last;
    } t_book_word;

    class order_table_model;
        localparam int DEPTH      = TABLE_DEPTH_DEF;
        localparam int REPORT_MAX = 10;

        logic               used   [DEPTH];
        logic               side   [DEPTH];
        logic [ID_W-1:0]    oid    [DEPTH];
        logic [PRICE_W-1:0] price  [DEPTH];
        logic [VOL_W-1:0]   volume [DEPTH];

        t_book_word due_words[$];
        int         mismatches;

        function void clear();
            foreach (used[i]) used[i] = 1'b0;
            due_words.delete();
            mismatches = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void push_word(t_status st, logic ev, logic [ID_W-1:0] id,
                                logic [PRICE_W-1:0] pr, logic [VOL_W-1:0] vol,
                                logic lst);
            t_book_word w;
            w.status      = st;
            w.entry_valid = ev;
            w.order_id    = id;
            w.price       = pr;
            w.volume      = vol;
            w.last        = lst;
            due_words.push_back(w);
        endfunction

        // apply one accepted command to the shadow table, queue its words
        function void post_command(t_cmd cmd, logic sd, logic [ID_W-1:0] id,
                                   logic [PRICE_W-1:0] pr, logic [VOL_W-1:0] vol);
            int   hit;
            int   free_slot;
            int   j;
            int   order_idx[$];
            logic found;
            hit       = -1;
            free_slot = -1;
            found     = 1'b0;
            case (cmd)
                CMD_ADD: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (used[i]) begin
                            if (hit < 0 && side[i] == sd && oid[i] == id) hit = i;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (hit < 0 && free_slot < 0) begin
                        push_word(ST_FULL, 1'b0, '0, '0, '0, 1'b1);
                    end else begin
                        if (hit < 0) begin
                            hit       = free_slot;
                            used[hit] = 1'b1;
                            side[hit] = sd;
                            oid[hit]  = id;
                        end
                        price[hit]  = pr;
                        volume[hit] = vol;
                        push_word(ST_DONE, 1'b0, '0, '0, '0, 1'b1);
                    end
                end
                CMD_EXEC, CMD_DEL: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (used[i] && oid[i] == id) begin
                            found = 1'b1;
                            if (cmd == CMD_DEL || volume[i] <= vol) used[i] = 1'b0;
                            else volume[i] = volume[i] - vol;
                        end
                    end
                    push_word(found ? ST_DONE : ST_NOT_FOUND, 1'b0, '0, '0, '0, 1'b1);
                end
                default: begin
                    // insertion sort: price ascending, then order id ascending
                    for (int i = 0; i < DEPTH; i++) begin
                        if (used[i] && side[i] == sd) begin
                            j = order_idx.size();
                            order_idx.push_back(i);
                            while (j > 0 && (price[i] < price[order_idx[j-1]] ||
                                   (price[i] == price[order_idx[j-1]] &&
                                    oid[i] < oid[order_idx[j-1]]))) begin
                                order_idx[j] = order_idx[j-1];
                                j--;
                            end
                            order_idx[j] = i;
                        end
                    end
                    if (order_idx.size() == 0) begin
                        push_word(ST_DONE, 1'b0, '0, '0, '0, 1'b1);
                    end else begin
                        foreach (order_idx[k]) begin
                            push_word(ST_DONE, 1'b1, oid[order_idx[k]],
                                      price[order_idx[k]], volume[order_idx[k]],
                                      k == order_idx.size() - 1);
                        end
                    end
                end
            endcase
        endfunction

        function void check_word(t_book_word got);
            t_book_word want;
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected word st=%0d ev=%b id=%h pr=%h vol=%h last=%b",
                             $time, got.status, got.entry_valid, got.order_id,
                             got.price, got.volume, got.last);
            end else begin
                want = due_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: word mismatch", $time);
                        $display("  expected st=%0d ev=%b id=%h pr=%h vol=%h last=%b",
                                 want.status, want.entry_valid, want.order_id,
                                 want.price, want.volume, want.last);
                        $display("  actual   st=%0d ev=%b id=%h pr=%h vol=%h last=%b",
                                 got.status, got.entry_valid, got.order_id,
                                 got.price, got.volume, got.last);
                    end
                end
            end
        endfunction
    endclass

endpackage

// File: tb/tb_order_book_table.sv
`timescale 1ns / 1ps

module tb_order_book_table;

    import obt_pkg::*;
    import obt_tb_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    // a single pass reads every slot; allow for long receiver stalls on top
    localparam int STUCK_LIMIT = 4000;
    localparam int MIXED_ITEMS = 15;
    localparam int FILL_ADDS   = DEPTH + 4;
    localparam int POOL_SIZE   = 16;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_cmd = CMD_ADD;
    logic               i_side = 1'b0;
    logic [ID_W-1:0]    i_order_id = '0;
    logic [PRICE_W-1:0] i_price = '0;
    logic [VOL_W-1:0]   i_volume = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_status;
    logic               o_entry_valid;
    logic [ID_W-1:0]    o_out_order_id;
    logic [PRICE_W-1:0] o_out_price;
    logic [VOL_W-1:0]   o_out_volume;
    logic               o_last;

    // idling odds in percent, changed per phase
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          stuck_cycles   = 0;

    logic [ID_W-1:0]  id_pool [POOL_SIZE];
    order_table_model table_model;

    order_book_table #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_side         (i_side),
        .i_order_id     (i_order_id),
        .i_price        (i_price),
        .i_volume       (i_volume),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_entry_valid  (o_entry_valid),
        .o_out_order_id (o_out_order_id),
        .o_out_price    (o_out_price),
        .o_out_volume   (o_out_volume),
        .o_last         (o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle off the falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // output monitor: every word taken is checked against the oldest expectation;
    // also counts cycles with no progress for the watchdog (a word nobody
    // expects is not progress)
    always @(posedge i_clk) begin
        t_book_word got;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) ||
                (o_valid && !i_stall && table_model.pending() != 0)) stuck_cycles = 0;
            else stuck_cycles = stuck_cycles + 1;
            if (o_valid && !i_stall) begin
                got.status      = t_status'(o_status);
                got.entry_valid = o_entry_valid;
                got.order_id    = o_out_order_id;
                got.price       = o_out_price;
                got.volume      = o_out_volume;
                got.last        = o_last;
                table_model.check_word(got);
            end
        end
    end

    // watchdog: nothing moving for too long ends the run
    initial begin : watchdog
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // --- stimulus helpers ---------------------------------------------------

    // one command word; entered and left on a falling edge
    task automatic send_cmd(t_cmd cmd, logic sd, logic [ID_W-1:0] id,
                            logic [PRICE_W-1:0] pr, logic [VOL_W-1:0] vol);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_side     <= sd;
        i_order_id <= id;
        i_price    <= pr;
        i_volume   <= vol;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // word taken at this edge
        table_model.post_command(cmd, sd, id, pr, vol);
        @(negedge i_clk);
    endtask

    // narrow prices give plenty of ties, so the id tie-break gets exercised
    function automatic logic [PRICE_W-1:0] rand_price();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) return PRICE_W'($urandom_range(7));
        if (r < 42) return '0;
        if (r < 50) return '1;
        return PRICE_W'($urandom);
    endfunction

    function automatic logic [VOL_W-1:0] rand_volume();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return VOL_W'($urandom_range(15));
        if (r < 40) return '0;
        if (r < 50) return '1;
        return VOL_W'($urandom);
    endfunction

    // mostly reused ids so that execute/delete/overwrite hit something
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(99) < 85) return id_pool[$urandom_range(POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    function automatic t_cmd pick_cmd();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) return CMD_ADD;
        if (r < 65) return CMD_EXEC;
        if (r < 80) return CMD_DEL;
        return CMD_DUMP;
    endfunction

    task automatic run_mixed(int count);
        repeat (count)
            send_cmd(pick_cmd(), 1'($urandom_range(1)), pick_id(), rand_price(),
                     rand_volume());
    endtask

    // fill past capacity with fresh ids, overwrite on a full table, dump both
    // sides, then drain with a mix of executes and deletes
    task automatic run_fill_burst();
        logic [ID_W-1:0] fill_ids[$];
        logic            fill_sides[$];
        logic [ID_W-1:0] fid;
        logic            fsd;
        for (int k = 0; k < FILL_ADDS; k++) begin
            fid = {$urandom, $urandom};
            fsd = 1'($urandom_range(1));
            fill_ids.push_back(fid);
            fill_sides.push_back(fsd);
            send_cmd(CMD_ADD, fsd, fid, rand_price(), rand_volume());
        end
        // existing key on a full table is still an overwrite
        send_cmd(CMD_ADD, fill_sides[0], fill_ids[0], rand_price(), rand_volume());
        send_cmd(CMD_DUMP, 1'b0, '0, '0, '0);
        send_cmd(CMD_DUMP, 1'b1, '0, '0, '0);
        foreach (fill_ids[k]) begin
            if ($urandom_range(1)) send_cmd(CMD_EXEC, 1'b0, fill_ids[k], '0, rand_volume());
            else send_cmd(CMD_DEL, 1'b0, fill_ids[k], '0, '0);
        end
    endtask

    // directed opening: empty dumps, unknown ids, extremes, overwrite,
    // zero volume, partial and full executes on both sides at once
    task automatic run_directed();
        send_cmd(CMD_DUMP, 1'b0, '0, '0, '0);
        send_cmd(CMD_DUMP, 1'b1, '0, '0, '0);
        send_cmd(CMD_EXEC, 1'b0, id_pool[5], '0, 32'd1);
        send_cmd(CMD_DEL,  1'b1, id_pool[6], '0, '0);
        send_cmd(CMD_ADD,  1'b0, '0, '0, '0);
        send_cmd(CMD_ADD,  1'b1, '1, '1, '1);
        send_cmd(CMD_ADD,  1'b0, id_pool[2], 32'd100, 32'd50);
        send_cmd(CMD_ADD,  1'b1, id_pool[2], 32'd100, 32'd70);
        send_cmd(CMD_ADD,  1'b0, id_pool[3], 32'd100, 32'd10);
        send_cmd(CMD_ADD,  1'b0, id_pool[4], 32'd100, 32'd10);
        send_cmd(CMD_ADD,  1'b0, id_pool[2], 32'd90, 32'd60);
        send_cmd(CMD_DUMP, 1'b0, '0, '0, '0);
        send_cmd(CMD_DUMP, 1'b1, '0, '0, '0);
        send_cmd(CMD_EXEC, 1'b0, '0, '0, '0);
        send_cmd(CMD_EXEC, 1'b0, id_pool[2], '0, 32'd55);
        send_cmd(CMD_DUMP, 1'b1, '0, '0, '0);
        send_cmd(CMD_EXEC, 1'b0, id_pool[2], '0, 32'd15);
        send_cmd(CMD_EXEC, 1'b0, id_pool[3], '0, '1);
        send_cmd(CMD_DEL,  1'b0, '1, '0, '0);
        send_cmd(CMD_DEL,  1'b0, id_pool[4], '0, '0);
        send_cmd(CMD_DUMP, 1'b0, '0, '0, '0);
        send_cmd(CMD_DUMP, 1'b1, '0, '0, '0);
    endtask

    // --- main sequence ------------------------------------------------------
    initial begin : main
        table_model = new;
        table_model.clear();
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) id_pool[k] = {$urandom, $urandom};

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // phase 0: no idling on either side
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_directed();
        run_mixed(MIXED_ITEMS);

        // phase 1: sender mostly idle
        send_idle_pct  = 70;
        recv_stall_pct = 0;
        run_mixed(MIXED_ITEMS);
        run_fill_burst();

        // phase 2: receiver mostly stalling
        send_idle_pct  = 0;
        recv_stall_pct = 70;
        run_mixed(MIXED_ITEMS);

        // phase 3: both sides idle a quarter of the time
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        run_fill_burst();
        run_mixed(MIXED_ITEMS);

        i_valid <= 1'b0;
        while (table_model.pending() != 0) @(posedge i_clk);
        // keep the clock running so that a stray extra word would still show up
        repeat (2 * (DEPTH + 3) + 10) @(posedge i_clk);

        if (table_model.mismatches == 0 && table_model.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
